// ===== src/anem_pkg.sv =====
// ----------------------------------------------------------------------------
// Anemometer speed and peak gust: shared definitions
// Field widths, scaling constants, request and result codes, the controller
// state type and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package anem_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 64;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SPEED_W    = 15;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG16_W    = 16;

  // pulse_count * wind_factor fits 32 bits; times 1000 fits 42 bits
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned NUM_W   = 42;

  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

  localparam logic [SCALE_W-1:0] MS_PER_S       = 10'd1000;
  localparam logic [TIME_W-1:0]  MIN_SAMPLE_MS  = 32'd100;
  localparam logic [TIME_W-1:0]  CACHE_FRESH_MS = 32'd1000;
  localparam logic [SPEED_W-1:0] SPEED_MAX      = 15'd20000;
  localparam logic [PULSE_W-1:0] PULSE_MAX      = 16'hFFFF;

  localparam logic [CFG16_W-1:0] DEBOUNCE_RST = 16'd10;
  localparam logic [CFG16_W-1:0] WIND_RST     = 16'd240;
  localparam logic [TIME_W-1:0]  WINDOW_RST   = 32'd300000;

  typedef enum logic [REQ_W-1:0] {
    REQ_PULSE  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_WIND     = 2'd1,
    CFG_WINDOW   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_SAMPLE_SKIP,
    RES_QUERY_CACHED,
    RES_QUERY_EMPTY,
    RES_SCAN
  } res_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_SCAN,
    ST_DRAIN,
    ST_PEAK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic     latch;
    logic     pulse_upd;
    logic     first_sample;
    logic     mul_load;
    logic     div_step;
    logic     store;
    logic     scan_start;
    logic     scan_step;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic started;
    logic short_gap;
    logic fresh;
    logic empty;
    logic div_done;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

// ===== src/anem_req_if.sv =====
// ----------------------------------------------------------------------------
// Anemometer request channel
// Valid/ready channel carrying one request item: request code and time.
// ----------------------------------------------------------------------------
interface anem_req_if;
  logic                             valid;
  logic                             ready;
  logic [anem_pkg::REQ_W-1:0]       req_type;
  logic [anem_pkg::TIME_W-1:0]      now_ms;

  modport source (output valid, output req_type, output now_ms, input ready);
  modport sink   (input valid, input req_type, input now_ms, output ready);
endinterface

// ===== src/anem_res_if.sv =====
// ----------------------------------------------------------------------------
// Anemometer result channel
// Valid/ready channel carrying one result item: kind, speed, stored, peak.
// ----------------------------------------------------------------------------
interface anem_res_if;
  logic                          valid;
  logic                          ready;
  logic                          out_kind;
  logic [anem_pkg::SPEED_W-1:0]  speed_centi;
  logic                          stored;
  logic [anem_pkg::SPEED_W-1:0]  peak_centi;

  modport source (output valid, output out_kind, output speed_centi, output stored,
                  output peak_centi, input ready);
  modport sink   (input valid, input out_kind, input speed_centi, input stored,
                  input peak_centi, output ready);
endinterface

// ===== src/anem_ctrl.sv =====
// ----------------------------------------------------------------------------
// Anemometer controller
// Sequences one item at a time: evaluate, multiply, divide, store, scan, reply.
// ----------------------------------------------------------------------------
module anem_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  anem_pkg::status_t status,
  output logic              req_ready,
  output anem_pkg::cmd_t    cmd
);

  anem_pkg::state_t state;
  anem_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= anem_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      anem_pkg::ST_IDLE: begin
        if (req_valid) state_next = anem_pkg::ST_EVAL;
      end
      anem_pkg::ST_EVAL: begin
        case (status.req)
          anem_pkg::REQ_SAMPLE: begin
            if (!status.started || status.short_gap) state_next = anem_pkg::ST_RESP;
            else state_next = anem_pkg::ST_MUL;
          end
          anem_pkg::REQ_QUERY: begin
            if (status.fresh || status.empty) state_next = anem_pkg::ST_RESP;
            else state_next = anem_pkg::ST_SCAN;
          end
          default: state_next = anem_pkg::ST_IDLE;
        endcase
      end
      anem_pkg::ST_MUL:   state_next = anem_pkg::ST_DIV;
      anem_pkg::ST_DIV: begin
        if (status.div_done) state_next = anem_pkg::ST_STORE;
      end
      anem_pkg::ST_STORE: state_next = anem_pkg::ST_SCAN;
      anem_pkg::ST_SCAN: begin
        if (status.scan_last) state_next = anem_pkg::ST_DRAIN;
      end
      anem_pkg::ST_DRAIN: state_next = anem_pkg::ST_PEAK;
      anem_pkg::ST_PEAK:  state_next = anem_pkg::ST_RESP;
      anem_pkg::ST_RESP: begin
        if (status.out_free) state_next = anem_pkg::ST_IDLE;
      end
      default: state_next = anem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      anem_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.latch = req_valid;
      end
      anem_pkg::ST_EVAL: begin
        case (status.req)
          anem_pkg::REQ_PULSE: cmd.pulse_upd = 1'b1;
          anem_pkg::REQ_SAMPLE: begin
            if (!status.started) begin
              cmd.first_sample = 1'b1;
              cmd.res_sel      = anem_pkg::RES_SAMPLE_SKIP;
            end else if (status.short_gap) begin
              cmd.res_sel = anem_pkg::RES_SAMPLE_SKIP;
            end
          end
          anem_pkg::REQ_QUERY: begin
            if (status.fresh) cmd.res_sel = anem_pkg::RES_QUERY_CACHED;
            else if (status.empty) cmd.res_sel = anem_pkg::RES_QUERY_EMPTY;
            else cmd.scan_start = 1'b1;
          end
          default: ;
        endcase
      end
      anem_pkg::ST_MUL: cmd.mul_load = 1'b1;
      anem_pkg::ST_DIV: cmd.div_step = 1'b1;
      anem_pkg::ST_STORE: begin
        cmd.store      = 1'b1;
        cmd.scan_start = 1'b1;
      end
      anem_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      anem_pkg::ST_PEAK: cmd.res_sel = anem_pkg::RES_SCAN;
      anem_pkg::ST_RESP: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== src/anem_dp.sv =====
// ----------------------------------------------------------------------------
// Anemometer datapath
// Config registers, pulse counter, multiplier, restoring divider, history
// memory with scan comparator, pending result and output register.
// ----------------------------------------------------------------------------
module anem_dp #(
  parameter int unsigned HISTORY_DEPTH = anem_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  anem_pkg::cmd_t                   cmd,
  output anem_pkg::status_t                status,
  input  logic [anem_pkg::REQ_W-1:0]       req_type,
  input  logic [anem_pkg::TIME_W-1:0]      now_ms,
  input  logic                             cfg_we,
  input  logic [anem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [anem_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             rsp_ready,
  output logic                             rsp_valid,
  output logic                             rsp_out_kind,
  output logic [anem_pkg::SPEED_W-1:0]     rsp_speed_centi,
  output logic                             rsp_stored,
  output logic [anem_pkg::SPEED_W-1:0]     rsp_peak_centi
);

  localparam int unsigned TW = anem_pkg::TIME_W;
  localparam int unsigned SW = anem_pkg::SPEED_W;
  localparam int unsigned NW = anem_pkg::NUM_W;
  localparam int unsigned ENTRY_W = TW + SW;
  localparam int unsigned ADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(HISTORY_DEPTH);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(HISTORY_DEPTH - 1);

  // configuration
  logic [anem_pkg::CFG16_W-1:0] debounce_ms;
  logic [anem_pkg::CFG16_W-1:0] wind_factor;
  logic [TW-1:0]                window_ms;

  // latched item
  anem_pkg::req_t req_r;
  logic [TW-1:0]  now_r;

  // state
  logic [anem_pkg::PULSE_W-1:0] pulse_count;
  logic [TW-1:0]                last_pulse_time;
  logic [TW-1:0]                last_sample_time;
  logic [ADDR_W-1:0]            write_pos;
  logic [FILL_W-1:0]            fill_count;
  logic [SW-1:0]                cached_peak;
  logic [TW-1:0]                peak_time;

  // arithmetic
  logic [anem_pkg::PROD_W-1:0]    prod1;
  logic [NW-1:0]                  prod2;
  logic [NW-1:0]                  quot;
  logic [TW-1:0]                  rem;
  logic [TW-1:0]                  div_d;
  logic [anem_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [TW:0]                    rem_sh;
  logic                           rem_ge;
  logic [TW:0]                    rem_sub;
  logic [SW-1:0]                  speed_sat;

  // history and scan
  logic [ENTRY_W-1:0] hist [HISTORY_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_vld;
  logic [ADDR_W-1:0]  scan_idx;
  logic [SW-1:0]      best;
  logic [TW-1:0]      rd_time;
  logic [SW-1:0]      rd_speed;
  logic [TW-1:0]      rd_age;

  // pending result
  logic          pend_kind;
  logic [SW-1:0] pend_speed;
  logic          pend_stored;
  logic [SW-1:0] pend_peak;

  logic [TW-1:0] delta;
  logic [TW-1:0] pulse_gap;
  logic [TW-1:0] cache_age;

  assign delta     = now_r - last_sample_time;
  assign pulse_gap = now_r - last_pulse_time;
  assign cache_age = now_r - peak_time;

  assign prod2 = {{(NW - anem_pkg::PROD_W){1'b0}}, prod1}
               * {{(NW - anem_pkg::SCALE_W){1'b0}}, anem_pkg::MS_PER_S};

  assign rem_sh  = {rem, quot[NW-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_d};
  assign rem_sub = rem_sh - {1'b0, div_d};

  assign speed_sat = (quot > NW'(anem_pkg::SPEED_MAX)) ? anem_pkg::SPEED_MAX : quot[SW-1:0];

  assign rd_time  = rd_data[ENTRY_W-1:SW];
  assign rd_speed = rd_data[SW-1:0];
  assign rd_age   = now_r - rd_time;

  always_comb begin
    status           = '0;
    status.req       = req_r;
    status.started   = last_sample_time != '0;
    status.short_gap = delta < anem_pkg::MIN_SAMPLE_MS;
    status.fresh     = cache_age < anem_pkg::CACHE_FRESH_MS;
    status.empty     = fill_count == '0;
    status.div_done  = div_cnt == anem_pkg::DIV_LAST;
    status.scan_last = FILL_W'(scan_idx) == (fill_count - FILL_W'(1));
    status.out_free  = !rsp_valid || rsp_ready;
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms      <= anem_pkg::DEBOUNCE_RST;
      wind_factor      <= anem_pkg::WIND_RST;
      window_ms        <= anem_pkg::WINDOW_RST;
      pulse_count      <= '0;
      last_pulse_time  <= '0;
      last_sample_time <= '0;
      write_pos        <= '0;
      fill_count       <= '0;
      cached_peak      <= '0;
      peak_time        <= '0;
      rd_vld           <= 1'b0;
      rsp_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (anem_pkg::cfg_idx_t'(cfg_index))
          anem_pkg::CFG_DEBOUNCE: debounce_ms <= cfg_data[anem_pkg::CFG16_W-1:0];
          anem_pkg::CFG_WIND:     wind_factor <= cfg_data[anem_pkg::CFG16_W-1:0];
          anem_pkg::CFG_WINDOW:   window_ms   <= cfg_data[TW-1:0];
          default: ;
        endcase
      end
      if (cmd.pulse_upd && (pulse_gap > TW'(debounce_ms))) begin
        if (pulse_count != anem_pkg::PULSE_MAX) pulse_count <= pulse_count + 1'b1;
        last_pulse_time <= now_r;
      end
      if (cmd.first_sample) last_sample_time <= now_r;
      if (cmd.store) begin
        write_pos        <= (write_pos == ADDR_LAST) ? '0 : write_pos + 1'b1;
        if (fill_count != FILL_MAX) fill_count <= fill_count + 1'b1;
        pulse_count      <= '0;
        last_sample_time <= now_r;
        peak_time        <= now_r;
      end
      if (cmd.res_sel == anem_pkg::RES_SCAN && req_r == anem_pkg::REQ_SAMPLE) begin
        cached_peak <= best;
      end
      rd_vld <= cmd.scan_step;
      if (cmd.out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    prod1 <= anem_pkg::PROD_W'(pulse_count) * anem_pkg::PROD_W'(wind_factor);
    if (cmd.latch) begin
      req_r <= anem_pkg::req_t'(req_type);
      now_r <= now_ms;
    end
    if (cmd.mul_load) begin
      quot    <= prod2;
      rem     <= '0;
      div_d   <= delta;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
      quot    <= {quot[NW-2:0], rem_ge};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
      best     <= '0;
    end else begin
      if (cmd.scan_step) scan_idx <= scan_idx + 1'b1;
      if (rd_vld && (rd_age <= window_ms) && (rd_speed > best)) best <= rd_speed;
    end
    if (cmd.store) begin
      pend_kind   <= anem_pkg::KIND_SAMPLE;
      pend_speed  <= speed_sat;
      pend_stored <= 1'b1;
    end
    case (cmd.res_sel)
      anem_pkg::RES_SAMPLE_SKIP: begin
        pend_kind   <= anem_pkg::KIND_SAMPLE;
        pend_speed  <= '0;
        pend_stored <= 1'b0;
        pend_peak   <= cached_peak;
      end
      anem_pkg::RES_QUERY_CACHED: begin
        pend_kind   <= anem_pkg::KIND_QUERY;
        pend_speed  <= '0;
        pend_stored <= 1'b0;
        pend_peak   <= cached_peak;
      end
      anem_pkg::RES_QUERY_EMPTY: begin
        pend_kind   <= anem_pkg::KIND_QUERY;
        pend_speed  <= '0;
        pend_stored <= 1'b0;
        pend_peak   <= '0;
      end
      anem_pkg::RES_SCAN: begin
        pend_peak <= best;
        if (req_r != anem_pkg::REQ_SAMPLE) begin
          pend_kind   <= anem_pkg::KIND_QUERY;
          pend_speed  <= '0;
          pend_stored <= 1'b0;
        end
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      rsp_out_kind    <= pend_kind;
      rsp_speed_centi <= pend_speed;
      rsp_stored      <= pend_stored;
      rsp_peak_centi  <= pend_peak;
    end
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store) hist[write_pos] <= {now_r, speed_sat};
    if (cmd.scan_step) rd_data <= hist[scan_idx];
  end

endmodule

// ===== src/anemometer_speed_and_peak_gust_core.sv =====
// ----------------------------------------------------------------------------
// Anemometer speed and peak gust core
// Debounced pulse counting, speed per sample, timestamped history, peak gust.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: req_type (pulse edge, sample, peak query) and now_ms.
//   rsp returns one item per sample or peak query; pulse edges and the unused
//   request code give no item. cfg_we/cfg_index/cfg_data write debounce_ms,
//   wind_factor and window_ms; write them only while the core is idle.
// Sequence (one item at a time; req.ready is high only in the idle state):
//   pulse edge            : evaluate, then back to idle
//   sample, skipped       : evaluate, then load the result register
//   sample, stored        : multiply, 42-step restoring divider, store, then
//                           one history read per cycle over the filled entries
//   peak query, cached    : evaluate, reply; stale: history scan, then reply
//   The length of the sample path is set by the one-bit-per-cycle divider and
//   the single read port of the history memory.
// Reset clears the counters, time marks, ring pointer, fill count and cached
// peak; history contents are not cleared and only written entries are read.
// When the receiver stalls, the result waits in the output register and the
// core keeps taking items until a second result is ready, then holds it.
// ----------------------------------------------------------------------------
module anemometer_speed_and_peak_gust_core #(
  parameter int unsigned HISTORY_DEPTH = anem_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  anem_req_if.sink                            req,
  anem_res_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic [anem_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [anem_pkg::CFG_DATA_W-1:0]     cfg_data
);

  anem_pkg::cmd_t    cmd;
  anem_pkg::status_t status;

  // sequence control: one state per phase of the item
  anem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .status    (status),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  // arithmetic, history ring and result register
  anem_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_type        (req.req_type),
    .now_ms          (req.now_ms),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_out_kind    (rsp.out_kind),
    .rsp_speed_centi (rsp.speed_centi),
    .rsp_stored      (rsp.stored),
    .rsp_peak_centi  (rsp.peak_centi)
  );

`ifndef SYNTH
  // an accepted item always moves the controller out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("ready stayed high after an accepted item");

  // a stored sample is a sample answer with a saturated speed
  a_stored_kind: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.stored |->
      rsp.out_kind == logic'(anem_pkg::KIND_SAMPLE) &&
      rsp.speed_centi <= anem_pkg::SPEED_MAX)
    else $error("stored flag on a bad result");

  // a query answer never carries a speed
  a_query_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.out_kind == logic'(anem_pkg::KIND_QUERY) |->
      rsp.speed_centi == '0 && !rsp.stored)
    else $error("query answer carries speed");

  // peak values come only from saturated speeds
  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.peak_centi <= anem_pkg::SPEED_MAX)
    else $error("peak above saturation limit");
`endif

endmodule
